/* sv/acc8_pkg.sv */
// Shared types and constants for the eight-bit accumulator processor core.
package acc8_pkg;

    localparam int unsigned ADDRESS_BITS_DEF = 13;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_VEC_LO = 3'd1,
        STEP_VEC_HI = 3'd2,
        STEP_OPCODE = 3'd3,
        STEP_A      = 3'd4,
        STEP_B      = 3'd5,
        STEP_C      = 3'd6,
        STEP_D      = 3'd7
    } step_t;

    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_ADC_ZP  = 8'h65;
    localparam logic [7:0] OP_AND_IMM = 8'h29;
    localparam logic [7:0] OP_AND_ZP  = 8'h25;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_STX_ZP  = 8'h86;
    localparam logic [7:0] OP_STY_ZP  = 8'h84;
    localparam logic [7:0] OP_STA_ZPX = 8'h95;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_BCC     = 8'h90;
    localparam logic [7:0] OP_BCS     = 8'hB0;
    localparam logic [7:0] OP_BEQ     = 8'hF0;
    localparam logic [7:0] OP_BNE     = 8'hD0;
    localparam logic [7:0] OP_JMP     = 8'h4C;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_RTS     = 8'h60;
    localparam logic [7:0] OP_ASL     = 8'h0A;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_DEX     = 8'hCA;
    localparam logic [7:0] OP_DEY     = 8'h88;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TYA     = 8'h98;

    localparam logic [15:0] VEC_LO     = 16'hFFFC;
    localparam logic [15:0] VEC_HI     = 16'hFFFD;
    localparam logic [7:0]  SP_RESET   = 8'hFD;
    localparam logic [7:0]  FLAG_RESET = 8'h24;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [0:0] CMD_DATA    = 1'b0;
    localparam logic [0:0] CMD_RESTART = 1'b1;

    // Architectural state carried between items.
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
        logic [7:0]  op;
        step_t       step;
        logic [15:0] latch;
        logic [31:0] total;
    } core_state_t;

    // One bus request with its completion report.
    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic        done;
        logic [2:0]  charge;
    } bus_req_t;

endpackage

/* sv/acc8_exec.sv */
// Next-state and bus-request logic for one bus access of the core.
module acc8_exec
(
    input  acc8_pkg::core_state_t cur,
    input  logic                  restart,
    input  logic [7:0]            din,
    output acc8_pkg::core_state_t nxt,
    output acc8_pkg::bus_req_t    req,
    output logic                  emit
);

    logic [8:0]  sum;
    logic [7:0]  zpx;
    logic [15:0] full;
    logic        taken;
    logic        fin;
    logic [2:0]  cyc;
    logic [7:0]  opv;
    logic        use_op;

    always_comb
    begin
        nxt    = cur;
        req    = '0;
        emit   = 1'b1;
        fin    = 1'b0;
        cyc    = 3'd2;
        use_op = 1'b0;
        opv    = din;
        zpx    = din + cur.x;
        full   = {din, cur.latch[7:0]};
        sum    = 9'(cur.a) + 9'(din) + 9'(cur.p[acc8_pkg::FL_C]);
        taken  = 1'b0;
        case (cur.op)
            acc8_pkg::OP_BCC: taken = !cur.p[acc8_pkg::FL_C];
            acc8_pkg::OP_BCS: taken = cur.p[acc8_pkg::FL_C];
            acc8_pkg::OP_BEQ: taken = cur.p[acc8_pkg::FL_Z];
            default:          taken = !cur.p[acc8_pkg::FL_Z];
        endcase

        if (restart)
        begin
            nxt.sp    = acc8_pkg::SP_RESET;
            nxt.p[acc8_pkg::FL_I] = 1'b1;
            nxt.total = '0;
            req.addr  = acc8_pkg::VEC_LO;
            nxt.step  = acc8_pkg::STEP_VEC_LO;
        end
        else
        begin
            case (cur.step)
                acc8_pkg::STEP_IDLE: emit = 1'b0;
                acc8_pkg::STEP_VEC_LO:
                begin
                    nxt.latch = {8'h00, din};
                    req.addr  = acc8_pkg::VEC_HI;
                    nxt.step  = acc8_pkg::STEP_VEC_HI;
                end
                acc8_pkg::STEP_VEC_HI:
                begin
                    req.addr = full;
                    nxt.pc   = full + 16'd1;
                    nxt.step = acc8_pkg::STEP_OPCODE;
                end
                acc8_pkg::STEP_OPCODE:
                begin
                    nxt.op = din;
                    case (din)
                        acc8_pkg::OP_ADC_IMM, acc8_pkg::OP_AND_IMM, acc8_pkg::OP_LDA_IMM,
                        acc8_pkg::OP_LDX_IMM, acc8_pkg::OP_LDY_IMM, acc8_pkg::OP_ADC_ZP,
                        acc8_pkg::OP_AND_ZP, acc8_pkg::OP_LDA_ZP, acc8_pkg::OP_LDX_ZP,
                        acc8_pkg::OP_LDA_ZPX, acc8_pkg::OP_STA_ZP, acc8_pkg::OP_STX_ZP,
                        acc8_pkg::OP_STY_ZP, acc8_pkg::OP_STA_ZPX, acc8_pkg::OP_LDA_ABS,
                        acc8_pkg::OP_STA_ABS, acc8_pkg::OP_BCC, acc8_pkg::OP_BCS,
                        acc8_pkg::OP_BEQ, acc8_pkg::OP_BNE:
                        begin
                            req.addr = cur.pc;
                            nxt.pc   = cur.pc + 16'd1;
                            nxt.step = acc8_pkg::STEP_A;
                        end
                        acc8_pkg::OP_JMP:
                        begin
                            req.addr = cur.pc;
                            nxt.step = acc8_pkg::STEP_A;
                        end
                        acc8_pkg::OP_JSR:
                        begin
                            nxt.latch = cur.pc + 16'd1;
                            req.addr  = {acc8_pkg::STACK_PAGE, cur.sp};
                            req.wr    = 1'b1;
                            req.wdata = nxt.latch[15:8];
                            nxt.sp    = cur.sp - 8'd1;
                            nxt.step  = acc8_pkg::STEP_A;
                        end
                        acc8_pkg::OP_RTS:
                        begin
                            nxt.sp   = cur.sp + 8'd1;
                            req.addr = {acc8_pkg::STACK_PAGE, nxt.sp};
                            nxt.step = acc8_pkg::STEP_A;
                        end
                        default:
                        begin
                            fin = 1'b1;
                            case (din)
                                acc8_pkg::OP_ASL:
                                begin
                                    nxt.p[acc8_pkg::FL_C] = cur.a[7];
                                    nxt.a = {cur.a[6:0], 1'b0};
                                end
                                acc8_pkg::OP_CLC: nxt.p[acc8_pkg::FL_C] = 1'b0;
                                acc8_pkg::OP_CLD: nxt.p[acc8_pkg::FL_D] = 1'b0;
                                acc8_pkg::OP_DEX: nxt.x = cur.x - 8'd1;
                                acc8_pkg::OP_DEY: nxt.y = cur.y - 8'd1;
                                acc8_pkg::OP_INX: nxt.x = cur.x + 8'd1;
                                acc8_pkg::OP_INY: nxt.y = cur.y + 8'd1;
                                acc8_pkg::OP_TAX: nxt.x = cur.a;
                                acc8_pkg::OP_TAY: nxt.y = cur.a;
                                acc8_pkg::OP_TXA: nxt.a = cur.x;
                                acc8_pkg::OP_TYA: nxt.a = cur.y;
                                default: ;
                            endcase
                            case (din)
                                acc8_pkg::OP_ASL, acc8_pkg::OP_TXA, acc8_pkg::OP_TYA:
                                begin
                                    nxt.p[acc8_pkg::FL_Z] = (nxt.a == 8'd0);
                                    nxt.p[acc8_pkg::FL_N] = nxt.a[7];
                                end
                                acc8_pkg::OP_DEX, acc8_pkg::OP_INX, acc8_pkg::OP_TAX:
                                begin
                                    nxt.p[acc8_pkg::FL_Z] = (nxt.x == 8'd0);
                                    nxt.p[acc8_pkg::FL_N] = nxt.x[7];
                                end
                                acc8_pkg::OP_DEY, acc8_pkg::OP_INY, acc8_pkg::OP_TAY:
                                begin
                                    nxt.p[acc8_pkg::FL_Z] = (nxt.y == 8'd0);
                                    nxt.p[acc8_pkg::FL_N] = nxt.y[7];
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end
                default:
                begin
                    case (cur.op)
                        acc8_pkg::OP_ADC_IMM, acc8_pkg::OP_AND_IMM, acc8_pkg::OP_LDA_IMM,
                        acc8_pkg::OP_LDX_IMM, acc8_pkg::OP_LDY_IMM:
                        begin
                            use_op = 1'b1;
                            fin    = 1'b1;
                        end
                        acc8_pkg::OP_ADC_ZP, acc8_pkg::OP_AND_ZP, acc8_pkg::OP_LDA_ZP,
                        acc8_pkg::OP_LDX_ZP, acc8_pkg::OP_LDA_ZPX:
                        begin
                            if (cur.step == acc8_pkg::STEP_A)
                            begin
                                req.addr = {8'h00,
                                    (cur.op == acc8_pkg::OP_LDA_ZPX) ? zpx : din};
                                nxt.step = acc8_pkg::STEP_B;
                            end
                            else
                            begin
                                use_op = 1'b1;
                                fin    = 1'b1;
                                cyc    = (cur.op == acc8_pkg::OP_LDA_ZPX) ? 3'd4 : 3'd3;
                            end
                        end
                        acc8_pkg::OP_LDA_ABS, acc8_pkg::OP_STA_ABS:
                        begin
                            if (cur.step == acc8_pkg::STEP_A)
                            begin
                                nxt.latch = {8'h00, din};
                                req.addr  = cur.pc;
                                nxt.pc    = cur.pc + 16'd1;
                                nxt.step  = acc8_pkg::STEP_B;
                            end
                            else if (cur.step == acc8_pkg::STEP_B)
                            begin
                                nxt.latch = full;
                                req.addr  = full;
                                if (cur.op == acc8_pkg::OP_STA_ABS)
                                begin
                                    req.wr    = 1'b1;
                                    req.wdata = cur.a;
                                end
                                nxt.step = acc8_pkg::STEP_C;
                            end
                            else
                            begin
                                use_op = (cur.op == acc8_pkg::OP_LDA_ABS);
                                fin    = 1'b1;
                                cyc    = 3'd4;
                            end
                        end
                        acc8_pkg::OP_STA_ZP, acc8_pkg::OP_STX_ZP, acc8_pkg::OP_STY_ZP,
                        acc8_pkg::OP_STA_ZPX:
                        begin
                            if (cur.step == acc8_pkg::STEP_A)
                            begin
                                req.addr = {8'h00,
                                    (cur.op == acc8_pkg::OP_STA_ZPX) ? zpx : din};
                                req.wr   = 1'b1;
                                req.wdata = (cur.op == acc8_pkg::OP_STX_ZP) ? cur.x :
                                            (cur.op == acc8_pkg::OP_STY_ZP) ? cur.y : cur.a;
                                nxt.step = acc8_pkg::STEP_B;
                            end
                            else
                            begin
                                fin = 1'b1;
                                cyc = (cur.op == acc8_pkg::OP_STA_ZPX) ? 3'd4 : 3'd3;
                            end
                        end
                        acc8_pkg::OP_BCC, acc8_pkg::OP_BCS, acc8_pkg::OP_BEQ,
                        acc8_pkg::OP_BNE:
                        begin
                            fin = 1'b1;
                            if (taken)
                            begin
                                nxt.pc = cur.pc + {{8{din[7]}}, din};
                                cyc    = 3'd3;
                            end
                        end
                        acc8_pkg::OP_JMP:
                        begin
                            if (cur.step == acc8_pkg::STEP_A)
                            begin
                                nxt.latch = {8'h00, din};
                                req.addr  = cur.pc + 16'd1;
                                nxt.step  = acc8_pkg::STEP_B;
                            end
                            else
                            begin
                                nxt.pc = full;
                                fin    = 1'b1;
                                cyc    = 3'd3;
                            end
                        end
                        acc8_pkg::OP_JSR:
                        begin
                            case (cur.step)
                                acc8_pkg::STEP_A:
                                begin
                                    req.addr  = {acc8_pkg::STACK_PAGE, cur.sp};
                                    req.wr    = 1'b1;
                                    req.wdata = cur.latch[7:0];
                                    nxt.sp    = cur.sp - 8'd1;
                                    nxt.step  = acc8_pkg::STEP_B;
                                end
                                acc8_pkg::STEP_B:
                                begin
                                    req.addr = cur.pc;
                                    nxt.step = acc8_pkg::STEP_C;
                                end
                                acc8_pkg::STEP_C:
                                begin
                                    nxt.latch = {8'h00, din};
                                    req.addr  = cur.pc + 16'd1;
                                    nxt.step  = acc8_pkg::STEP_D;
                                end
                                default:
                                begin
                                    nxt.pc = full;
                                    fin    = 1'b1;
                                    cyc    = 3'd6;
                                end
                            endcase
                        end
                        acc8_pkg::OP_RTS:
                        begin
                            if (cur.step == acc8_pkg::STEP_A)
                            begin
                                nxt.latch = {8'h00, din};
                                nxt.sp    = cur.sp + 8'd1;
                                req.addr  = {acc8_pkg::STACK_PAGE, nxt.sp};
                                nxt.step  = acc8_pkg::STEP_B;
                            end
                            else
                            begin
                                nxt.pc = full + 16'd1;
                                fin    = 1'b1;
                                cyc    = 3'd6;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            endcase

            if (use_op)
            begin
                case (cur.op)
                    acc8_pkg::OP_ADC_IMM, acc8_pkg::OP_ADC_ZP:
                    begin
                        nxt.a = sum[7:0];
                        nxt.p[acc8_pkg::FL_C] = sum[8];
                        nxt.p[acc8_pkg::FL_V] = ~(cur.a[7] ^ din[7]) & (cur.a[7] ^ sum[7]);
                        opv = sum[7:0];
                    end
                    acc8_pkg::OP_AND_IMM, acc8_pkg::OP_AND_ZP:
                    begin
                        nxt.a = cur.a & din;
                        opv   = cur.a & din;
                    end
                    acc8_pkg::OP_LDX_IMM, acc8_pkg::OP_LDX_ZP: nxt.x = din;
                    acc8_pkg::OP_LDY_IMM: nxt.y = din;
                    default: nxt.a = din;
                endcase
                nxt.p[acc8_pkg::FL_Z] = (opv == 8'd0);
                nxt.p[acc8_pkg::FL_N] = opv[7];
            end

            // Finished instruction: charge it and fetch the next opcode.
            if (fin)
            begin
                nxt.total  = cur.total + 32'(cyc);
                req.done   = 1'b1;
                req.charge = cyc;
                req.addr   = nxt.pc;
                req.wr     = 1'b0;
                req.wdata  = '0;
                nxt.pc     = nxt.pc + 16'd1;
                nxt.step   = acc8_pkg::STEP_OPCODE;
            end
        end
    end

endmodule

/* sv/eight_bit_accumulator_cpu_core.sv */
// Top level of the eight-bit accumulator processor core with stream ports.
//
// Channel  Dir  tdata (low bit first)                                    tuser
// s_axis   in   read_data[7:0]                                           operation
// m_axis   out  bus_address, bus_write, write_data, instruction_done,    -
//               cycles_charged, total_cycles, acc, x, y, sp, flags, pc
//
// One item per clock when not stalled: one pass of acc8_exec between the state
// registers and the output register. Result appears the cycle after accept.
// Reset puts the core idle; data items before a restart give no result.
// A full output register that is not taken holds s_axis_tready low.
module eight_bit_accumulator_cpu_core #(
    parameter int unsigned ADDRESS_BITS = acc8_pkg::ADDRESS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // read_data
    input  logic                        s_axis_tuser,   // operation
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // bus_address, bus_write, write_data, instruction_done, cycles_charged,
    // total_cycles, acc_value, x_value, y_value, stack_value, flags_value, pc_value
    output logic [((ADDRESS_BITS+101+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned OUT_BITS = ADDRESS_BITS + 101;
    localparam int unsigned PAD_BITS = ((OUT_BITS + 7) / 8) * 8 - OUT_BITS;

    acc8_pkg::core_state_t st_reg, st_next;
    acc8_pkg::bus_req_t    req;
    logic                  emit;
    logic                  accept;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    acc8_exec u_exec (
        .cur     (st_reg),
        .restart (s_axis_tuser == acc8_pkg::CMD_RESTART),
        .din     (s_axis_tdata),
        .nxt     (st_next),
        .req     (req),
        .emit    (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: acc8_pkg::SP_RESET,
                               p: acc8_pkg::FLAG_RESET, pc: 16'd0, op: 8'd0,
                               step: acc8_pkg::STEP_IDLE, latch: 16'd0, total: 32'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= {st_next.pc, st_next.p, st_next.sp, st_next.y, st_next.x,
                             st_next.a, st_next.total, req.charge, req.done,
                             (req.wr ? req.wdata : 8'd0), req.wr,
                             req.addr[ADDRESS_BITS-1:0]};
        end
    end

    assign m_axis_tdata = {{PAD_BITS{1'b0}}, out_data_reg};

    property p_no_emit_idle;
        @(posedge clk) disable iff (!rst_n)
        (accept && st_reg.step == acc8_pkg::STEP_IDLE &&
         s_axis_tuser == acc8_pkg::CMD_DATA) |=> !($past(emit));
    endproperty
    a_no_emit_idle: assert property (p_no_emit_idle) else $error("idle item emitted");

    property p_charge_done;
        @(posedge clk) disable iff (!rst_n)
        (accept && emit) |-> (req.done == (req.charge != 3'd0));
    endproperty
    a_charge_done: assert property (p_charge_done) else $error("charge without done");

    property p_total;
        @(posedge clk) disable iff (!rst_n)
        (accept && emit && s_axis_tuser == acc8_pkg::CMD_DATA) |->
            (st_next.total == st_reg.total + 32'(req.charge));
    endproperty
    a_total: assert property (p_total) else $error("total mismatch");

    property p_restart;
        @(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == acc8_pkg::CMD_RESTART) |=>
            (st_reg.step == acc8_pkg::STEP_VEC_LO && st_reg.total == 32'd0);
    endproperty
    a_restart: assert property (p_restart) else $error("restart state wrong");

endmodule
